@@ hw/rtl/skt_pkg.sv @@
`default_nettype none
package skt_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 4096;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Field widths
    localparam int CFG_W   = 13;
    localparam int INDEX_W = 12;
    localparam int KEY_W   = 64;
    localparam int DATA_W  = 32;
    localparam int ENTRY_W = KEY_W + 3 * DATA_W;

    // Input and output word widths, padded to whole bytes
    localparam int S_PAYLOAD_W = INDEX_W + KEY_W + 3 * DATA_W;
    localparam int S_TDATA_W   = ((S_PAYLOAD_W + 7) / 8) * 8;
    localparam int M_TDATA_W   = 3 * DATA_W;

    // Operation codes carried on s_tuser
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // Lookup request handed to the search engine
    typedef struct packed {
        logic             start;
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] used;
    } skt_req_t;

    // Lookup result returned by the search engine
    typedef struct packed {
        logic              valid;
        logic              found;
        logic [DATA_W-1:0] list_offset;
        logic [DATA_W-1:0] list_length;
        logic [DATA_W-1:0] occurrences;
    } skt_res_t;

endpackage
`default_nettype wire

@@ hw/rtl/skt_ram.sv @@
`default_nettype none
// Simple dual-port RAM: one write port, one registered read port.
module skt_ram #(
    parameter int ADDR_BITS = 12,
    parameter int DATA_BITS = 160
) (
    input  wire logic                 clk,
    input  wire logic                 wr_en,
    input  wire logic [ADDR_BITS-1:0] wr_addr,
    input  wire logic [DATA_BITS-1:0] wr_data,
    input  wire logic [ADDR_BITS-1:0] rd_addr,
    output logic      [DATA_BITS-1:0] rd_data
);

    logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

@@ hw/rtl/skt_search.sv @@
`default_nettype none
// Lower-bound binary search engine. One halving step per cycle: the read
// address for the next step is the midpoint of the updated bounds, so the
// entry arrives from the RAM just as the next step needs it. Once the bounds
// meet, that midpoint is the lower bound itself and its entry is checked.
module skt_search (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire skt_pkg::skt_req_t            req,
    output logic                              busy,
    output logic [skt_pkg::ADDR_W-1:0]        rd_addr,
    input  wire logic [skt_pkg::ENTRY_W-1:0]  rd_data,
    input  wire logic                         res_ready,
    output skt_pkg::skt_res_t                 res
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic                        state_reg, state_next;
    logic [skt_pkg::CNT_W-1:0]   lo_reg, lo_next;
    logic [skt_pkg::CNT_W-1:0]   hi_reg, hi_next;
    logic [skt_pkg::CNT_W-1:0]   used_reg;
    logic [skt_pkg::KEY_W-1:0]   key_reg;
    logic [skt_pkg::CNT_W:0]     cur_sum, next_sum;
    logic [skt_pkg::CNT_W-1:0]   cur_mid;
    logic [skt_pkg::KEY_W-1:0]   entry_key;
    logic                        converged;
    logic                        key_less;

    // Entry layout from the lowest bit up: key, offset, length, count.
    assign entry_key = rd_data[skt_pkg::KEY_W-1:0];
    assign converged = (lo_reg == hi_reg);
    assign key_less  = (entry_key < key_reg);
    assign cur_sum   = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign cur_mid   = cur_sum[skt_pkg::CNT_W:1];

    always_comb
    begin
        state_next = state_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        res        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.start)
                begin
                    lo_next    = '0;
                    hi_next    = req.used;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (!converged)
                begin
                    if (key_less)
                    begin
                        lo_next = cur_mid + skt_pkg::CNT_W'(1);
                    end
                    else
                    begin
                        hi_next = cur_mid;
                    end
                end
                else if (res_ready)
                begin
                    res.valid = 1'b1;
                    if ((lo_reg < used_reg) && (entry_key == key_reg))
                    begin
                        res.found       = 1'b1;
                        res.list_offset = rd_data[skt_pkg::KEY_W +: skt_pkg::DATA_W];
                        res.list_length =
                            rd_data[skt_pkg::KEY_W + skt_pkg::DATA_W +: skt_pkg::DATA_W];
                        res.occurrences =
                            rd_data[skt_pkg::KEY_W + 2 * skt_pkg::DATA_W +: skt_pkg::DATA_W];
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // A lower bound equal to the table depth wraps to a valid address; the
    // range check on the result masks that read.
    assign next_sum = {1'b0, lo_next} + {1'b0, hi_next};
    assign rd_addr  = next_sum[skt_pkg::ADDR_W:1];
    assign busy     = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            lo_reg    <= '0;
            hi_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && req.start)
        begin
            key_reg  <= req.key;
            used_reg <= req.used;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/sorted_key_table_binary_search_core.sv @@
`default_nettype none
// Sorted key table with lower-bound binary search lookup.
//
// The s_ channel takes one word per item; s_tuser selects the operation.
// A write word stores one entry at entry_index and produces no result. A
// lookup word searches the first entries_in_use entries, which software
// keeps sorted ascending by key, and produces one m_ word: m_tuser is the
// found flag, m_tdata the entry data, or zeros on a miss.
//
// A lookup takes ceil(log2(n+1)) halving steps for n entries in use, one
// table RAM read each, plus a final step that checks the entry at the lower
// bound. s_tready is low while a lookup runs, so the block takes no new word
// until the lookup hands its result to the output register; writes go back
// to back.
//
// The cfg channel writes entries_in_use; it is always ready and must be
// written only while the block is idle. Values above the table depth are
// treated as the depth. Reset clears entries_in_use and all control state;
// table contents are undefined until written. When the receiver stalls, the
// finished result holds in the output register; writes are still taken, and
// a following lookup waits at its last step until that register frees up.
module sorted_key_table_binary_search_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    // Configuration: entries_in_use
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [skt_pkg::CFG_W-1:0]      cfg_data,

    // Input words
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // s_tdata from bit 0: entry_index, key, list_offset_in, list_length_in,
    // occurrences_in, zero padding
    input  wire logic [skt_pkg::S_TDATA_W-1:0]  s_tdata,
    // s_tuser: op
    input  wire logic                           s_tuser,

    // Result words
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // m_tdata from bit 0: list_offset, list_length, occurrences
    output logic [skt_pkg::M_TDATA_W-1:0]       m_tdata,
    // m_tuser: found
    output logic                                m_tuser
);

    localparam int KEY_LSB = skt_pkg::INDEX_W;
    localparam int OFF_LSB = KEY_LSB + skt_pkg::KEY_W;

    logic [skt_pkg::CFG_W-1:0]    used_cfg_reg;
    logic [skt_pkg::CNT_W-1:0]    used_clamped;
    logic [skt_pkg::INDEX_W-1:0]  in_index;
    logic [skt_pkg::KEY_W-1:0]    in_key;
    logic                         accept;
    logic                         wr_en;
    logic                         busy;
    logic [skt_pkg::ADDR_W-1:0]   rd_addr;
    logic [skt_pkg::ENTRY_W-1:0]  rd_data;
    logic                         res_ready;
    skt_pkg::skt_req_t            req;
    skt_pkg::skt_res_t            res;

    logic                         m_valid_reg;
    logic                         found_reg;
    logic [skt_pkg::M_TDATA_W-1:0] m_data_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_cfg_reg <= '0;
        end
        else if (cfg_valid)
        begin
            used_cfg_reg <= cfg_data;
        end
    end

    always_comb
    begin
        if (32'(used_cfg_reg) >= 32'(skt_pkg::TABLE_DEPTH))
        begin
            used_clamped = skt_pkg::CNT_W'(skt_pkg::TABLE_DEPTH);
        end
        else
        begin
            used_clamped = skt_pkg::CNT_W'(used_cfg_reg);
        end
    end

    assign in_index = s_tdata[skt_pkg::INDEX_W-1:0];
    assign in_key   = s_tdata[KEY_LSB +: skt_pkg::KEY_W];
    assign s_tready = !busy;
    assign accept   = s_tvalid && s_tready;

    // Writes beyond the table depth are dropped.
    assign wr_en = accept && (s_tuser == skt_pkg::OP_WRITE)
                   && (32'(in_index) < 32'(skt_pkg::TABLE_DEPTH));

    assign req.start = accept && (s_tuser == skt_pkg::OP_LOOKUP);
    assign req.key   = in_key;
    assign req.used  = used_clamped;

    skt_ram #(
        .ADDR_BITS (skt_pkg::ADDR_W),
        .DATA_BITS (skt_pkg::ENTRY_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (skt_pkg::ADDR_W'(in_index)),
        .wr_data ({s_tdata[OFF_LSB +: 3 * skt_pkg::DATA_W], in_key}),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    skt_search u_search (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .busy      (busy),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .res_ready (res_ready),
        .res       (res)
    );

    // The output register can take a new result when empty or draining.
    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (res.valid)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            found_reg  <= res.found;
            m_data_reg <= {res.occurrences, res.list_length, res.list_offset};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = found_reg;

endmodule
`default_nettype wire
